>>> design/mfd_pkg.sv
package mfd_pkg;

  // Stream payload widths, packed to whole bytes
  localparam int unsigned InDataWidth  = 80;
  localparam int unsigned OutDataWidth = 144;

  // Configuration port
  localparam int unsigned CfgAddrWidth = 3;
  localparam int unsigned CfgDataWidth = 32;
  localparam logic        REG_MOTOR_ID = 1'b0;
  localparam logic [10:0] MOTOR_ID_RESET = 11'd1;

  // Reply opcodes carried in byte 0 of a 5-byte frame
  localparam logic [7:0] OP_POSITION    = 8'h08;
  localparam logic [7:0] OP_ERROR       = 8'h0A;
  localparam logic [7:0] OP_TEMPERATURE = 8'h31;

  localparam logic [3:0] LEN_SHORT = 4'd5;
  localparam logic [3:0] LEN_LONG  = 4'd8;

  // degrees = counts * 360 / (65536 * 101) = counts * 45 / (8192 * 101)
  localparam int unsigned DegScaleMul   = 45;
  localparam int unsigned DegScaleShift = 13;
  // floor(r / 101) = (r * RecipMul) >> RecipShift, exact for r below 2^24
  localparam logic [24:0] RecipMul   = 25'd21262215;
  localparam int unsigned RecipShift = 31;

  typedef enum logic [2:0] {
    KIND_NONE        = 3'd0,
    KIND_POSITION    = 3'd1,
    KIND_COMBINED    = 3'd2,
    KIND_ERROR       = 3'd3,
    KIND_TEMPERATURE = 3'd4
  } frame_kind_t;

  typedef struct packed {
    logic [10:0]     frame_id;
    logic [3:0]      length;
    logic [7:0][7:0] data;
  } frame_t;

  // Held values after one frame, plus what the frame was
  typedef struct packed {
    logic               accepted;
    frame_kind_t        kind;
    logic signed [31:0] position;
    logic signed [15:0] current;
    logic signed [15:0] speed;
    logic [15:0]        temperature;
    logic [31:0]        error;
    logic               pose_ready;
  } snapshot_t;

  function automatic logic [7:0] compact_error(input logic [31:0] e);
    return {e[17] | e[18], e[16], e[6], e[5], e[4], e[2], e[1], e[0]};
  endfunction

endpackage

>>> design/mfd_cfg.sv
module mfd_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mfd_pkg::CfgAddrWidth-1:0]  paddr,
  input  logic [mfd_pkg::CfgDataWidth-1:0]  pwdata,
  output logic [mfd_pkg::CfgDataWidth-1:0]  prdata,
  output logic                              pready,
  output logic [10:0]                       motor_id
);
  import mfd_pkg::*;

  logic reg_index;
  logic wr_en;

  assign reg_index = paddr[CfgAddrWidth-1];
  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      motor_id <= MOTOR_ID_RESET;
    end else if (wr_en && (reg_index == REG_MOTOR_ID)) begin
      motor_id <= pwdata[10:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_index == REG_MOTOR_ID) begin
      prdata = {{(CfgDataWidth-11){1'b0}}, motor_id};
    end
  end

endmodule

>>> design/mfd_decode.sv
module mfd_decode (
  input  logic               clk,
  input  logic               rst,
  input  logic [10:0]        motor_id,
  input  mfd_pkg::frame_t    frame,
  input  logic               update,
  output mfd_pkg::snapshot_t snap
);
  import mfd_pkg::*;

  logic [31:0] held_position;
  logic [15:0] held_current;
  logic [15:0] held_speed;
  logic [15:0] held_temperature;
  logic [31:0] held_error;
  logic        ready_flag;

  logic [31:0] held_position_next;
  logic [15:0] held_current_next;
  logic [15:0] held_speed_next;
  logic [15:0] held_temperature_next;
  logic [31:0] held_error_next;
  logic        ready_flag_next;
  frame_kind_t kind;
  logic [31:0] word_short;
  logic        id_match;

  assign word_short = {frame.data[4], frame.data[3], frame.data[2], frame.data[1]};
  assign id_match   = (frame.frame_id == motor_id);

  always_comb begin
    held_position_next    = held_position;
    held_current_next     = held_current;
    held_speed_next       = held_speed;
    held_temperature_next = held_temperature;
    held_error_next       = held_error;
    ready_flag_next       = ready_flag;
    kind                  = KIND_NONE;
    if (id_match) begin
      if ((frame.length == LEN_SHORT) && (frame.data[0] == OP_POSITION)) begin
        held_position_next = word_short;
        ready_flag_next    = 1'b1;
        kind               = KIND_POSITION;
      end else if (frame.length == LEN_LONG) begin
        held_current_next  = {frame.data[1], frame.data[0]};
        held_speed_next    = {frame.data[3], frame.data[2]};
        held_position_next = {frame.data[7], frame.data[6], frame.data[5], frame.data[4]};
        ready_flag_next    = 1'b1;
        kind               = KIND_COMBINED;
      end else if ((frame.length == LEN_SHORT) && (frame.data[0] == OP_ERROR)) begin
        held_error_next = word_short;
        kind            = KIND_ERROR;
      end else if ((frame.length == LEN_SHORT) && (frame.data[0] == OP_TEMPERATURE)) begin
        // clamp the signed value to 0..65535
        if (word_short[31]) begin
          held_temperature_next = 16'd0;
        end else if (word_short[30:16] != 15'd0) begin
          held_temperature_next = 16'hFFFF;
        end else begin
          held_temperature_next = word_short[15:0];
        end
        kind = KIND_TEMPERATURE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_position    <= '0;
      held_current     <= '0;
      held_speed       <= '0;
      held_temperature <= '0;
      held_error       <= '0;
      ready_flag       <= 1'b0;
    end else if (update) begin
      held_position    <= held_position_next;
      held_current     <= held_current_next;
      held_speed       <= held_speed_next;
      held_temperature <= held_temperature_next;
      held_error       <= held_error_next;
      ready_flag       <= ready_flag_next;
    end
  end

  always_comb begin
    snap.accepted    = (kind != KIND_NONE);
    snap.kind        = kind;
    snap.position    = held_position_next;
    snap.current     = held_current_next;
    snap.speed       = held_speed_next;
    snap.temperature = held_temperature_next;
    snap.error       = held_error_next;
    snap.pose_ready  = ready_flag_next;
  end

endmodule

>>> design/mfd_degrees.sv
module mfd_degrees (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  mfd_pkg::snapshot_t in_snap,
  output logic               out_valid,
  input  logic               out_ready,
  output mfd_pkg::snapshot_t out_snap,
  output logic [15:0]        out_degrees
);
  import mfd_pkg::*;

  // Scale stage: magnitude times 45, drop 13 bits
  logic        c_valid;
  snapshot_t   c_snap;
  logic [23:0] c_scaled;
  logic        c_neg;

  logic        c_ready;
  logic        d_ready;
  logic [31:0] mag;
  logic [37:0] mag_x45;
  logic [48:0] recip_prod;
  logic [17:0] quot;
  logic [15:0] degrees_next;

  assign d_ready  = !out_valid || out_ready;
  assign c_ready  = !c_valid || d_ready;
  assign in_ready = c_ready;

  always_comb begin
    mag     = in_snap.position[31] ? (~in_snap.position) + 32'd1 : in_snap.position;
    mag_x45 = {6'd0, mag} * 38'(DegScaleMul);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (c_ready) begin
      c_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready && in_valid) begin
      c_snap   <= in_snap;
      c_scaled <= mag_x45[DegScaleShift +: 24];
      c_neg    <= in_snap.position[31];
    end
  end

  // Divide by 101 through the reciprocal, then sign and saturate
  always_comb begin
    recip_prod = {25'd0, c_scaled} * {24'd0, RecipMul};
    quot       = recip_prod[RecipShift +: 18];
    if (!c_neg) begin
      degrees_next = (quot > 18'd32767) ? 16'h7FFF : quot[15:0];
    end else begin
      degrees_next = (quot > 18'd32768) ? 16'h8000 : (~quot[15:0]) + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (d_ready) begin
      out_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (d_ready && c_valid) begin
      out_snap    <= c_snap;
      out_degrees <= degrees_next;
    end
  end

endmodule

>>> design/motor_feedback_frame_decoder.sv
// Motor feedback frame decoder. Each received CAN frame (identifier, length
// and eight data bytes) enters as one slave-side transaction, and each frame,
// accepted or not, leaves as one master-side transaction that carries the
// latest held motor values: raw position, position in whole joint degrees
// (truncated toward zero, saturated to int16), current, speed, clamped
// temperature, the raw and compacted error word, and the pose-ready flag.
// Frames from any identifier other than motor_id leave the held values alone
// and report accepted = 0, frame_kind = 0. One frame is taken every clock
// cycle unless the master side stalls. The result passes through
// four registers (input register, decode register, scale register,
// result register). The depth is set by the two-step degree conversion that
// multiplies by 45 and then by the reciprocal of 101. Write motor_id through
// the APB port at address 0 only while no frame is in flight.
module motor_feedback_frame_decoder (
  input  logic                              clk,
  input  logic                              rst,
  // slave side: frame_id[10:0], length[14:11], byte0..byte7[78:15], zero[79]
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [mfd_pkg::InDataWidth-1:0]   s_axis_tdata,
  // master side: accepted[0], frame_kind[3:1], position_count[35:4],
  // position_degrees[51:36], drive_current[67:52], shaft_speed[83:68],
  // temperature[99:84], error_word[131:100], error_compact[139:132],
  // pose_ready[140], zero[143:141]
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [mfd_pkg::OutDataWidth-1:0]  m_axis_tdata,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mfd_pkg::CfgAddrWidth-1:0]  paddr,
  input  logic [mfd_pkg::CfgDataWidth-1:0]  pwdata,
  output logic [mfd_pkg::CfgDataWidth-1:0]  prdata,
  output logic                              pready
);
  import mfd_pkg::*;

  logic [10:0] motor_id;

  // Input register stage
  logic        a_valid;
  frame_t      a_frame;
  logic        a_adv;
  frame_t      in_frame;

  // Decode register stage
  logic        b_valid;
  snapshot_t   b_snap;
  logic        b_ready;
  snapshot_t   dec_snap;

  logic        conv_ready;
  snapshot_t   out_snap;
  logic [15:0] out_degrees;

  mfd_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .motor_id (motor_id)
  );

  // Unpack the frame from the slave-side data bus
  always_comb begin
    in_frame.frame_id = s_axis_tdata[10:0];
    in_frame.length   = s_axis_tdata[14:11];
    for (int i = 0; i < 8; i++) begin
      in_frame.data[i] = s_axis_tdata[15 + 8*i +: 8];
    end
  end

  assign b_ready       = !b_valid || conv_ready;
  assign a_adv         = a_valid && b_ready;
  assign s_axis_tready = !a_valid || b_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (s_axis_tready) begin
      a_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      a_frame <= in_frame;
    end
  end

  // Held state advances exactly when a frame moves into the decode register
  mfd_decode u_decode (
    .clk      (clk),
    .rst      (rst),
    .motor_id (motor_id),
    .frame    (a_frame),
    .update   (a_adv),
    .snap     (dec_snap)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      b_snap <= dec_snap;
    end
  end

  // Degree conversion, carrying the snapshot alongside to the result register
  mfd_degrees u_degrees (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (b_valid),
    .in_ready    (conv_ready),
    .in_snap     (b_snap),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_snap    (out_snap),
    .out_degrees (out_degrees)
  );

  // Pack the result; the compacted error follows straight from the held word
  assign m_axis_tdata = {
    3'b000,
    out_snap.pose_ready,
    compact_error(out_snap.error),
    out_snap.error,
    out_snap.temperature,
    out_snap.speed,
    out_snap.current,
    out_degrees,
    out_snap.position,
    out_snap.kind,
    out_snap.accepted
  };

endmodule

>>> design/mfd_checker.sv
module mfd_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [mfd_pkg::OutDataWidth-1:0]  m_axis_tdata
);
  import mfd_pkg::*;

  logic        accepted;
  logic [2:0]  kind;
  logic        pos_sign;
  logic        deg_sign;
  logic        pose_ready;

  assign accepted   = m_axis_tdata[0];
  assign kind       = m_axis_tdata[3:1];
  assign pos_sign   = m_axis_tdata[35];
  assign deg_sign   = m_axis_tdata[51];
  assign pose_ready = m_axis_tdata[140];

  // accepted flag agrees with the reported kind
  a_accept_kind: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (accepted == (kind != KIND_NONE)))
    else $error("accepted does not match frame_kind");

  // negative degrees only from a negative count
  a_deg_sign: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && deg_sign |-> pos_sign)
    else $error("position_degrees sign disagrees with position_count");

  // position-bearing replies raise pose_ready
  a_pose_ready: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && ((kind == KIND_POSITION) || (kind == KIND_COMBINED)) |-> pose_ready)
    else $error("pose_ready low after a position reply");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

endmodule

bind motor_feedback_frame_decoder mfd_checker u_mfd_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
